// File: hw/rtl/tcr_pkg.sv
// ---------------------------------------------------------------------------
// tcr_pkg
// Shared types and constants of the tabulated cooling-rate engine.
// ---------------------------------------------------------------------------
package tcr_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int QDEPTH      = 2;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic [0:0] REG_TABLE_SIZE = 1'b0;
    localparam logic [0:0] REG_FLOOR_RATE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [9:0]  entry_index;
        logic [31:0] entry_abscissa;
        logic signed [31:0] entry_rate;
        logic [31:0] query_value;
        logic [31:0] density;
        logic [31:0] rate_scale;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] energy_rhs;
        logic signed [31:0] interp_rate;
        logic [9:0]  bracket_index;
        logic [1:0]  status;
    } out_item_t;

    // front to back: classified work
    typedef struct packed {
        logic        is_load;
        logic [IDX_W-1:0] entry_index;
        logic [31:0] entry_abscissa;
        logic [31:0] entry_rate;
        logic [31:0] query_value;
        logic [31:0] density;
        logic [31:0] rate_scale;
    } work_t;

endpackage

// File: hw/rtl/tabulated_cooling_rate.sv
// ---------------------------------------------------------------------------
// tabulated_cooling_rate
// Piecewise-linear cooling-rate table engine with APB configuration.
// ---------------------------------------------------------------------------
// One item at a time in the back end. A load result is ready the cycle after
// the back end takes the load. A query holds the back end while it clamps
// and checks against the table ends, makes up to 10 table probes on the
// single RAM read port, fetches the bracketing pair, runs two 65-step
// bit-serial divisions with a setup state each, sums and clips, runs an
// 18-step limb-serial product chain and forms the result. A query below the
// table ends skips the probes and goes straight to the result; a zero-width
// interval skips both divisions. The next item is taken only once the result
// is accepted. A 2-entry queue in front takes items while the back end works
// and a finished result waits in the output register.
module tabulated_cooling_rate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tcr_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output tcr_pkg::out_item_t  out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tcr_pkg::*;

    logic [SIZE_W-1:0] table_size_reg;
    logic [31:0]       floor_rate_reg;
    logic              wk_valid, wk_take;
    work_t             wk;
    logic              wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_W'(2);
            floor_rate_reg <= '0;
        end
        else if (wr)
        begin
            unique case (paddr[2])
                REG_TABLE_SIZE: table_size_reg <= pwdata[SIZE_W-1:0];
                REG_FLOOR_RATE: floor_rate_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TABLE_SIZE: prdata = 32'(table_size_reg);
            default:        prdata = floor_rate_reg;
        endcase
    end

    tcr_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .wk_valid(wk_valid), .wk_take(wk_take), .wk(wk)
    );

    tcr_back u_back (
        .clk(clk), .rst_n(rst_n), .wk_valid(wk_valid), .wk_take(wk_take), .wk(wk),
        .table_size(table_size_reg), .floor_rate(floor_rate_reg),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wk_take |-> wk_valid) else $error("take without queued work");
    a_load_status: assert property (@(posedge clk) disable iff (!rst_n)
        (wk_take && wk.is_load) |=> (out_valid && out_item.status == ST_LOAD))
        else $error("load result missing");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_item)) else $error("result changed");
endmodule

// File: hw/rtl/tcr_ram.sv
// ---------------------------------------------------------------------------
// tcr_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module tcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: hw/rtl/tcr_front.sv
// ---------------------------------------------------------------------------
// tcr_front
// Accepts items, classifies them and queues them for the back end.
// ---------------------------------------------------------------------------
module tcr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tcr_pkg::in_item_t  in_item,
    output logic               wk_valid,
    input  logic               wk_take,
    output tcr_pkg::work_t     wk
);
    import tcr_pkg::*;

    work_t           q_reg [QDEPTH];
    logic [0:0]      wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    logic            push;
    work_t           w_in;

    assign in_stall = (cnt_reg == 2'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign wk_valid = (cnt_reg != 2'd0);
    assign wk       = q_reg[rp_reg];

    always_comb
    begin
        w_in.is_load        = (in_item.op == OP_LOAD);
        w_in.entry_index    = in_item.entry_index[IDX_W-1:0];
        w_in.entry_abscissa = in_item.entry_abscissa;
        w_in.entry_rate     = in_item.entry_rate;
        w_in.query_value    = in_item.query_value;
        w_in.density        = in_item.density;
        w_in.rate_scale     = in_item.rate_scale;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= w_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (wk_take)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(wk_take);
        end
    end
endmodule

// File: hw/rtl/tcr_back.sv
// ---------------------------------------------------------------------------
// tcr_back
// Executes loads and queries: table search, serial division, product chain.
// ---------------------------------------------------------------------------
module tcr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wk_valid,
    output logic                  wk_take,
    input  tcr_pkg::work_t        wk,
    input  logic [tcr_pkg::SIZE_W-1:0] table_size,
    input  logic [31:0]           floor_rate,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tcr_pkg::out_item_t    out_item
);
    import tcr_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RLAST = 5'd1;
    localparam logic [4:0] S_WLAST = 5'd2;
    localparam logic [4:0] S_RFST  = 5'd3;
    localparam logic [4:0] S_WFST  = 5'd4;
    localparam logic [4:0] S_PROBE = 5'd5;
    localparam logic [4:0] S_PWAIT = 5'd6;
    localparam logic [4:0] S_RLO   = 5'd7;
    localparam logic [4:0] S_RHI   = 5'd8;
    localparam logic [4:0] S_GETLO = 5'd9;
    localparam logic [4:0] S_GETHI = 5'd10;
    localparam logic [4:0] S_NUM1  = 5'd11;
    localparam logic [4:0] S_DIV   = 5'd12;
    localparam logic [4:0] S_NUM2  = 5'd13;
    localparam logic [4:0] S_SUM   = 5'd14;
    localparam logic [4:0] S_DIFF  = 5'd15;
    localparam logic [4:0] S_MUL   = 5'd16;
    localparam logic [4:0] S_FIN   = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    localparam int MAG_W = 33;
    localparam int NUM_W = 65;
    localparam int BIG_W = 192;
    localparam int SHIFT = 4 * FRAC_BITS - 32;

    logic [4:0]        st_reg;
    work_t             w_reg;
    logic [IDX_W-1:0]  klo_reg, khi_reg, last_reg, mid;
    logic [31:0]       v_reg, alo_reg, ahi_reg, rlo_reg, rhi_reg;
    logic              q2_reg;
    // divider
    logic [NUM_W-1:0]  dnum_reg, drem_reg;
    logic [32:0]       dden_reg;
    logic [6:0]        dcnt_reg;
    logic              dneg_reg;
    logic signed [64:0] q1_reg;
    logic signed [65:0] rate_reg;
    logic              sat_reg;
    // product chain
    logic [BIG_W-1:0]  big_reg;
    logic [1:0]        mstep_reg;
    logic [5:0]        limb_reg;
    logic [31:0]       carry_reg;
    logic [31:0]       mult;
    logic              neg_reg;
    out_item_t         o_reg;
    logic              ov_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_addr;
    logic [31:0]       a_rd, r_rd;
    logic [IDX_W:0]    nsat;

    tcr_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_abs (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wk.entry_abscissa), .rdata(a_rd)
    );
    tcr_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_rate (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wk.entry_rate), .rdata(r_rd)
    );

    assign mid = IDX_W'(({1'b0, klo_reg} + {1'b0, khi_reg}) >> 1);

    always_comb
    begin
        if (table_size < SIZE_W'(2))
            nsat = (IDX_W+1)'(2);
        else if (table_size > SIZE_W'(TABLE_DEPTH))
            nsat = (IDX_W+1)'(TABLE_DEPTH);
        else
            nsat = (IDX_W+1)'(table_size);
    end

    always_comb
    begin
        ram_we   = (st_reg == S_IDLE) && wk_valid && wk.is_load && !ov_reg;
        ram_addr = wk.entry_index;
        unique case (st_reg)
            S_IDLE:  ram_addr = wk.entry_index;
            S_RLAST: ram_addr = last_reg;
            S_RFST:  ram_addr = '0;
            S_PROBE: ram_addr = mid;
            S_RLO:   ram_addr = klo_reg;
            S_RHI:   ram_addr = khi_reg;
            default: ram_addr = klo_reg;
        endcase
    end

    always_comb
    begin
        unique case (mstep_reg)
            2'd2:    mult = w_reg.rate_scale;
            default: mult = w_reg.density;
        endcase
    end

    assign wk_take   = (st_reg == S_IDLE) && wk_valid && !ov_reg;
    assign out_valid = ov_reg;
    assign out_item  = o_reg;

    logic [NUM_W-1:0] drem_sh;
    logic [NUM_W-1:0] drem_sub;
    logic [63:0]      limb_prod;
    logic [BIG_W-1:0] shifted;
    logic             over;
    logic [63:0]      mag64;

    assign drem_sh   = {drem_reg[NUM_W-2:0], dnum_reg[NUM_W-1]};
    assign drem_sub  = drem_sh - NUM_W'(dden_reg);
    assign limb_prod = 64'(big_reg[limb_reg*32 +: 32]) * 64'(mult) + 64'(carry_reg);
    assign shifted   = big_reg >> SHIFT;
    assign over      = |shifted[BIG_W-1:64];
    assign mag64     = shifted[63:0];

    // magnitude of a signed value, used to start a signed division num/den
    function automatic logic [NUM_W-1:0] absn(input logic signed [65:0] x);
        logic signed [65:0] t;
        t = (x < 0) ? -x : x;
        return t[NUM_W-1:0];
    endfunction

    logic signed [65:0] num_a, num_b, wid;
    assign wid   = 66'($signed({2'b0, ahi_reg})) - 66'($signed({2'b0, alo_reg}));
    assign num_a = 66'(signed'(rlo_reg)) * (66'($signed({2'b0, ahi_reg})) - 66'($signed({2'b0, v_reg})));
    assign num_b = 66'(signed'(rhi_reg)) * (66'($signed({2'b0, v_reg})) - 66'($signed({2'b0, alo_reg})));

    logic signed [65:0] qv;
    assign qv = dneg_reg ? -66'($signed({1'b0, dnum_reg})) : 66'($signed({1'b0, dnum_reg}));

    // sign/magnitude of diff is loaded in S_FIN, before the first product step
    logic signed [65:0] dclip;
    assign dclip = 66'(signed'(floor_rate)) -
        ((rate_reg > 66'sd2147483647) ? 66'sd2147483647 :
         (rate_reg < -66'sd2147483648) ? -66'sd2147483648 : rate_reg);

    logic [63:0] dmag;
    assign dmag = (dclip < 0) ? 64'(-dclip) : 64'(dclip);

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
            begin
                w_reg    <= wk;
                last_reg <= IDX_W'(nsat - 1'b1);
            end
            S_WLAST:
            begin
                v_reg <= (w_reg.query_value > a_rd) ? a_rd : w_reg.query_value;
            end
            S_WFST:
            begin
                klo_reg <= '0;
                khi_reg <= last_reg;
                alo_reg <= a_rd;
            end
            S_PWAIT:
            begin
                if (v_reg <= a_rd)
                    khi_reg <= mid;
                else
                    klo_reg <= mid;
            end
            S_RHI:
            begin
                alo_reg <= a_rd;
                rlo_reg <= r_rd;
            end
            S_GETLO:
            begin
                ahi_reg <= a_rd;
                rhi_reg <= r_rd;
                q2_reg  <= 1'b0;
            end
            S_NUM1, S_NUM2:
            begin
                dnum_reg <= absn((st_reg == S_NUM1) ? num_a : num_b);
                dneg_reg <= ((st_reg == S_NUM1) ? num_a[65] : num_b[65]) ^ wid[65];
                dden_reg <= 33'(absn(wid));
                drem_reg <= '0;
                dcnt_reg <= 7'(NUM_W);
            end
            S_DIV:
            begin
                if (drem_sub[NUM_W-1] == 1'b0 || drem_sh >= NUM_W'(dden_reg))
                begin
                    if (drem_sh >= NUM_W'(dden_reg))
                    begin
                        drem_reg <= drem_sub;
                        dnum_reg <= {dnum_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= drem_sh;
                        dnum_reg <= {dnum_reg[NUM_W-2:0], 1'b0};
                    end
                end
                else
                begin
                    drem_reg <= drem_sh;
                    dnum_reg <= {dnum_reg[NUM_W-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == 7'd1 && !q2_reg)
                    q2_reg <= 1'b1;
            end
            S_SUM:
            begin
                if (wid == 0)
                    rate_reg <= 66'(signed'(rlo_reg));
                else
                    rate_reg <= 66'(q1_reg) + qv;
            end
            S_DIFF:
            begin
                sat_reg <= 1'b0;
                if (rate_reg > 66'sd2147483647)
                begin
                    rate_reg <= 66'sd2147483647;
                    sat_reg  <= 1'b1;
                end
                else if (rate_reg < -66'sd2147483648)
                begin
                    rate_reg <= -66'sd2147483648;
                    sat_reg  <= 1'b1;
                end
            end
            S_FIN:
            begin
                big_reg <= {128'b0, dmag};
                neg_reg <= dclip < 0;
            end
            S_MUL:
            begin
                big_reg[limb_reg*32 +: 32] <= limb_prod[31:0];
                carry_reg <= limb_prod[63:32];
                if (limb_reg == 6'd5)
                begin
                    limb_reg  <= '0;
                    carry_reg <= '0;
                    mstep_reg <= mstep_reg + 1'b1;
                end
                else
                begin
                    limb_reg <= limb_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (st_reg == S_NUM2)
            q1_reg <= 65'(qv);
        if (st_reg == S_SUM)
        begin
            limb_reg  <= '0;
            carry_reg <= '0;
            mstep_reg <= '0;
        end
        if (st_reg == S_WFST && v_reg < a_rd)
            mstep_reg <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            o_reg  <= '0;
        end
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (wk_take)
                    begin
                        if (wk.is_load)
                        begin
                            o_reg  <= '{energy_rhs: '0, interp_rate: '0,
                                        bracket_index: '0, status: ST_LOAD};
                            ov_reg <= 1'b1;
                        end
                        else
                        begin
                            st_reg <= S_RLAST;
                        end
                    end
                end
                S_RLAST: st_reg <= S_WLAST;
                S_WLAST: st_reg <= S_RFST;
                S_RFST:  st_reg <= S_WFST;
                S_WFST:
                begin
                    if (v_reg < a_rd)
                    begin
                        o_reg  <= '{energy_rhs: '0, interp_rate: '0,
                                    bracket_index: '0, status: ST_BELOW};
                        st_reg <= S_OUT;
                    end
                    else
                        st_reg <= (last_reg == IDX_W'(1)) ? S_RLO : S_PROBE;
                end
                S_PROBE: st_reg <= S_PWAIT;
                S_PWAIT:
                begin
                    if (IDX_W'(({1'b0, (v_reg <= a_rd) ? klo_reg : mid}) + 1'b1) ==
                        ((v_reg <= a_rd) ? mid : khi_reg))
                        st_reg <= S_RLO;
                    else
                        st_reg <= S_PROBE;
                end
                S_RLO:   st_reg <= S_RHI;
                S_RHI:   st_reg <= S_GETLO;
                S_GETLO: st_reg <= S_GETHI;
                S_GETHI: st_reg <= S_NUM1;
                S_NUM1:  st_reg <= (wid == 0) ? S_SUM : S_DIV;
                S_DIV:
                begin
                    if (dcnt_reg == 7'd1)
                        st_reg <= q2_reg ? S_SUM : S_NUM2;
                end
                S_NUM2:  st_reg <= S_DIV;
                S_SUM:   st_reg <= S_DIFF;
                S_DIFF:  st_reg <= S_FIN;
                S_FIN:   st_reg <= S_MUL;
                S_MUL:
                begin
                    if (limb_reg == 6'd5 && mstep_reg == 2'd2)
                        st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ov_reg <= 1'b1;
                        st_reg <= S_IDLE;
                        if (mstep_reg == 2'd3)
                        begin
                            o_reg.interp_rate   <= rate_reg[31:0];
                            o_reg.bracket_index <= 10'(klo_reg);
                            if (neg_reg)
                            begin
                                if (over || mag64 > 64'h8000000000000000)
                                begin
                                    o_reg.energy_rhs <= 64'h8000000000000000;
                                    o_reg.status     <= ST_SAT;
                                end
                                else
                                begin
                                    o_reg.energy_rhs <= -mag64;
                                    o_reg.status     <= sat_reg ? ST_SAT : ST_OK;
                                end
                            end
                            else
                            begin
                                if (over || mag64[63])
                                begin
                                    o_reg.energy_rhs <= 64'h7FFFFFFFFFFFFFFF;
                                    o_reg.status     <= ST_SAT;
                                end
                                else
                                begin
                                    o_reg.energy_rhs <= mag64;
                                    o_reg.status     <= sat_reg ? ST_SAT : ST_OK;
                                end
                            end
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: dv/tb_tabulated_cooling_rate.sv
// ---------------------------------------------------------------------------
// tb_tabulated_cooling_rate
// Self-checking bench for the tabulated cooling-rate engine. Table loads and
// rate queries go in through the valid/stall input channel. A scoreboard
// predicts every result and compares it field by field with what comes out.
// Phases vary table size, floor rate and the idle/stall pattern on each side.
// ---------------------------------------------------------------------------
module tb_tabulated_cooling_rate;
    timeunit 1ns;
    timeprecision 1ps;

    import tcr_pkg::*;

    localparam logic [2:0] ADDR_TABLE_SIZE = {REG_TABLE_SIZE, 2'b00};
    localparam logic [2:0] ADDR_FLOOR_RATE = {REG_FLOOR_RATE, 2'b00};
    localparam int         WATCHDOG_LIMIT  = 5000;

    class cooling_scoreboard;
        logic [31:0]        abscissa_tbl[TABLE_DEPTH];
        logic signed [31:0] rate_tbl[TABLE_DEPTH];
        logic [10:0]        size_reg;
        logic signed [31:0] floor_reg;
        out_item_t          expected_q[$];
        int                 errors;

        function new();
            foreach (abscissa_tbl[i])
            begin
                abscissa_tbl[i] = '0;
                rate_tbl[i] = '0;
            end
            size_reg = 11'd2;
            floor_reg = '0;
            errors = 0;
        endfunction

        function int entries_used();
            if (size_reg < 2)
                return 2;
            if (size_reg > TABLE_DEPTH)
                return TABLE_DEPTH;
            return size_reg;
        endfunction

        function void configure(logic [2:0] addr, logic [31:0] value);
            if (addr == ADDR_TABLE_SIZE)
                size_reg = value[10:0];
            else if (addr == ADDR_FLOOR_RATE)
                floor_reg = value;
        endfunction

        function void note_input(in_item_t it);
            out_item_t          res;
            int                 last, klo, khi, mid;
            logic [31:0]        v;
            longint             a_lo, a_hi, vv, width, r_lo, r_hi, q1, q2, rate, diff;
            logic signed [64:0] sum65;
            logic [63:0]        mag;
            logic [191:0]       prod;
            bit                 sat, neg;

            res = '0;
            sat = 0;
            if (it.op == OP_LOAD)
            begin
                abscissa_tbl[it.entry_index] = it.entry_abscissa;
                rate_tbl[it.entry_index] = it.entry_rate;
                res.status = ST_LOAD;
                expected_q.push_back(res);
                return;
            end
            last = entries_used() - 1;
            v = it.query_value;
            if (v > abscissa_tbl[last])
                v = abscissa_tbl[last];
            if (v < abscissa_tbl[0])
            begin
                res.status = ST_BELOW;
                expected_q.push_back(res);
                return;
            end
            klo = 0;
            khi = last;
            while (klo + 1 != khi)
            begin
                mid = (klo + khi) / 2;
                if (v <= abscissa_tbl[mid])
                    khi = mid;
                else
                    klo = mid;
            end
            a_lo = abscissa_tbl[klo];
            a_hi = abscissa_tbl[khi];
            vv = v;
            r_lo = rate_tbl[klo];
            r_hi = rate_tbl[khi];
            width = a_hi - a_lo;
            if (width == 0)
                rate = r_lo;
            else
            begin
                q1 = (r_lo * (a_hi - vv)) / width;
                q2 = (r_hi * (vv - a_lo)) / width;
                sum65 = q1 + q2;
                if (sum65 > 65'sh0_7FFF_FFFF_FFFF_FFFF)
                    rate = 64'sh7FFF_FFFF_FFFF_FFFF;
                else if (sum65 < -65'sh0_8000_0000_0000_0000)
                    rate = 64'sh8000_0000_0000_0000;
                else
                    rate = sum65[63:0];
            end
            if (rate > 64'sh7FFF_FFFF)
            begin
                rate = 64'sh7FFF_FFFF;
                sat = 1;
            end
            if (rate < -64'sh8000_0000)
            begin
                rate = -64'sh8000_0000;
                sat = 1;
            end
            diff = longint'(floor_reg) - rate;
            neg = diff < 0;
            mag = neg ? -diff : diff;
            prod = 192'(mag);
            prod = prod * it.density;
            prod = prod * it.density;
            prod = prod * it.rate_scale;
            prod = prod >> (4 * FRAC_BITS - 32);
            mag = prod[63:0];
            if (neg)
            begin
                if (|prod[191:64] || mag > 64'h8000_0000_0000_0000)
                begin
                    mag = 64'h8000_0000_0000_0000;
                    sat = 1;
                end
                res.energy_rhs = -mag;
            end
            else
            begin
                if (|prod[191:64] || mag > 64'h7FFF_FFFF_FFFF_FFFF)
                begin
                    mag = 64'h7FFF_FFFF_FFFF_FFFF;
                    sat = 1;
                end
                res.energy_rhs = mag;
            end
            res.interp_rate = rate[31:0];
            res.bracket_index = klo[9:0];
            res.status = sat ? ST_SAT : ST_OK;
            expected_q.push_back(res);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %0t: %s got %h expected %h", $time, what, got, want);
            errors++;
        endtask

        task check(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected item", got.status, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.energy_rhs !== want.energy_rhs)
                report("energy_rhs", got.energy_rhs, want.energy_rhs);
            if (got.interp_rate !== want.interp_rate)
                report("interp_rate", got.interp_rate, want.interp_rate);
            if (got.bracket_index !== want.bracket_index)
                report("bracket_index", got.bracket_index, want.bracket_index);
            if (got.status !== want.status)
                report("status", got.status, want.status);
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;
    logic      psel;
    logic      penable;
    logic      pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cooling_scoreboard sb;
    int idle_mode;
    int quiet_cycles;

    tabulated_cooling_rate dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (idle_mode == 2)
            out_stall <= ($urandom_range(99) < 69);
        else if (idle_mode == 3)
            out_stall <= ($urandom_range(99) < 15);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(out_item);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task send_item(in_item_t it);
        int gap, pct;
        gap = 0;
        pct = (idle_mode == 1) ? 69 : (idle_mode == 3) ? 15 : 0;
        while ($urandom_range(99) < pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(it);
    endtask

    task load_entry(int idx, logic [31:0] absc, logic [31:0] rate);
        in_item_t it;
        it = '0;
        it.op = OP_LOAD;
        it.entry_index = idx[9:0];
        it.entry_abscissa = absc;
        it.entry_rate = rate;
        it.query_value = $urandom;
        it.density = $urandom;
        it.rate_scale = $urandom;
        send_item(it);
    endtask

    task query(logic [31:0] v, logic [31:0] dens, logic [31:0] scale);
        in_item_t it;
        it = '0;
        it.op = OP_QUERY;
        it.entry_index = $urandom;
        it.entry_abscissa = $urandom;
        it.entry_rate = $urandom;
        it.query_value = v;
        it.density = dens;
        it.rate_scale = scale;
        send_item(it);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task apb_write(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.configure(addr, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function logic [31:0] pick_rate();
        if ($urandom_range(3) == 0)
            return $urandom;
        return $urandom_range(32'h0100_0000) - 32'h0080_0000;
    endfunction

    function logic [31:0] pick_factor();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h0000_0FFF);
            default: return $urandom_range(32'h0003_FFFF);
        endcase
    endfunction

    task fill_table(int n, bit sorted);
        logic [31:0] a, step_max;
        a = $urandom_range(32'h0002_0000);
        step_max = 32'hF000_0000 / n;
        for (int i = 0; i < n; i++)
        begin
            if (sorted)
                load_entry(i, a, pick_rate());
            else
                load_entry(i, $urandom, pick_rate());
            a = a + (($urandom_range(9) == 0) ? 0 : $urandom_range(step_max, 1));
        end
    endtask

    task random_items(int count);
        logic [31:0] a0, al, lo, hi;
        int last;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < 12)
                load_entry($urandom_range(TABLE_DEPTH - 1), $urandom, pick_rate());
            else
            begin
                last = sb.entries_used() - 1;
                a0 = sb.abscissa_tbl[0];
                al = sb.abscissa_tbl[last];
                lo = (a0 < al) ? a0 : al;
                hi = (a0 < al) ? al : a0;
                case ($urandom_range(7))
                    0: query($urandom, pick_factor(), pick_factor());
                    1: query(sb.abscissa_tbl[$urandom_range(last)], pick_factor(),
                             pick_factor());
                    default: query($urandom_range(hi, lo), pick_factor(), pick_factor());
                endcase
            end
        end
    endtask

    initial
    begin
        int sizes[6];
        logic [31:0] floors[6];

        sb = new();
        idle_mode = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_write(ADDR_TABLE_SIZE, 32'd2);
        apb_write(ADDR_FLOOR_RATE, 32'd0);

        load_entry(0, 32'h0001_0000, 32'h0010_0000);
        load_entry(1, 32'h0005_0000, 32'h0020_0000);
        load_entry(TABLE_DEPTH - 1, 32'hFFFF_FFFF, 32'h8000_0000);
        query(32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
        query(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        query(32'h0003_0000, 32'h0002_0000, 32'h0000_8000);
        query(32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000);
        query(32'h0003_8000, 32'h0000_0000, 32'hFFFF_FFFF);
        query(32'h0003_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        query(32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        load_entry(1, 32'h0001_0000, 32'h7FFF_FFFF);
        query(32'h0001_0000, 32'h0003_0000, 32'h0001_0000);
        query(32'h0009_0000, 32'hFFFF_FFFF, 32'h0010_0000);
        load_entry(0, 32'h0000_0000, 32'h8000_0000);
        load_entry(1, 32'hFFFF_FFFF, 32'h8000_0000);
        query(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        query(32'h8000_0000, 32'h0000_1000, 32'h0000_1000);
        query(32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000);
        drain();

        sizes = '{5, 1, 40, 150, 0, 17};
        floors = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                   $urandom, pick_rate()};
        for (int p = 0; p < 6; p++)
        begin
            idle_mode = p % 4;
            apb_write(ADDR_TABLE_SIZE, sizes[p]);
            apb_write(ADDR_FLOOR_RATE, floors[p]);
            if (p != 4)
                fill_table(sb.entries_used(), p != 5);
            random_items(50);
            drain();
        end

        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
